// ===== hw/rtl/nfc_pkg.sv =====
// ----------------------------------------------------------------------------
// nfc_pkg: shared types and constants for the nearest free cell search
// Action codes, scan side codes, default storage sizes and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nfc_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  localparam int GRID_W = 6;   // grid size register width
  localparam int ACT_W  = 2;
  localparam int COORD_W = 5;  // row / column field width

  // action codes
  localparam logic [ACT_W-1:0] ACT_WR     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SRCH   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLAIM  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  // ring sides, in scan order
  localparam logic [1:0] SIDE_N = 2'd0;
  localparam logic [1:0] SIDE_E = 2'd1;
  localparam logic [1:0] SIDE_S = 2'd2;
  localparam logic [1:0] SIDE_W = 2'd3;

  typedef struct packed {
    logic load_item;
    logic ring_init;
    logic ring_next;
    logic side_init;
    logic side_next;
    logic step;
    logic hit;
    logic claim;
    logic wr_item;
    logic out_load;
  } nfc_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             wr_ok;
    logic             org_ok;
    logic             side_live;
    logic             side_last;
    logic             cell_last;
    logic             cell_free;
    logic             ring_in;
  } nfc_sts_t;

endpackage

// ===== hw/rtl/nfc_dp.sv =====
// ----------------------------------------------------------------------------
// nfc_dp: search datapath
// Grid size registers, occupancy row memory with per-row valid bits, ring
// bound registers, side walker and result registers.
// ----------------------------------------------------------------------------
module nfc_dp #(
  parameter int MAX_ROWS = nfc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = nfc_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [nfc_pkg::GRID_W-1:0]    cfg_wdata,
  input  logic [nfc_pkg::ACT_W-1:0]     in_action,
  input  logic [nfc_pkg::COORD_W-1:0]   in_row,
  input  logic [nfc_pkg::COORD_W-1:0]   in_col,
  input  logic                          in_occupied,
  input  nfc_pkg::nfc_cmd_t             cmd,
  output nfc_pkg::nfc_sts_t             sts,
  output logic                          out_found,
  output logic [nfc_pkg::COORD_W-1:0]   out_found_row,
  output logic [nfc_pkg::COORD_W-1:0]   out_found_col
);

  localparam int MAXRC = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int MAXD  = (MAXRC > 32) ? MAXRC : 32;
  localparam int SW    = $clog2(2 * MAXD + 1) + 1;
  localparam int RA    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CA    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam logic signed [SW-1:0] ZERO_S = '0;
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);
  localparam logic signed [SW-1:0] MAXR_S = SW'(MAX_ROWS);
  localparam logic signed [SW-1:0] MAXC_S = SW'(MAX_COLS);

  // grid size registers
  logic [nfc_pkg::GRID_W-1:0] gcols_r, grows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcols_r <= nfc_pkg::GRID_W'(32);
      grows_r <= nfc_pkg::GRID_W'(32);
    end else if (cfg_we) begin
      if (cfg_idx == nfc_pkg::REG_GRID_COLS) gcols_r <= cfg_wdata;
      else                                   grows_r <= cfg_wdata;
    end
  end

  logic signed [SW-1:0] gc_ext, gr_ext, nc, nr;

  always_comb begin
    gc_ext = SW'(gcols_r);
    gr_ext = SW'(grows_r);
    if (gc_ext == ZERO_S)     nc = ONE_S;
    else if (gc_ext > MAXC_S) nc = MAXC_S;
    else                      nc = gc_ext;
    if (gr_ext == ZERO_S)     nr = ONE_S;
    else if (gr_ext > MAXR_S) nr = MAXR_S;
    else                      nr = gr_ext;
  end

  // item registers
  logic [nfc_pkg::ACT_W-1:0] act_r;
  logic signed [SW-1:0]      r0_r, c0_r, d_r;
  logic                      occ_r;

  // ring bounds and walker
  logic signed [SW-1:0] north_r, south_r, west_r, east_r;
  logic signed [SW-1:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic signed [SW-1:0] pos_r, end_r;
  logic [1:0]           side_r;
  logic                 inside_r;

  logic signed [SW-1:0] north_w, south_w, west_w, east_w;
  logic signed [SW-1:0] xlo_w, xhi_w, ylo_w, yhi_w;

  always_comb begin
    north_w = r0_r - d_r;
    south_w = r0_r + d_r;
    west_w  = c0_r - d_r;
    east_w  = c0_r + d_r;
    xhi_w   = (east_w < nc - ONE_S) ? east_w : nc - ONE_S;
    xlo_w   = (west_w > ZERO_S) ? west_w : ZERO_S;
    ylo_w   = (north_w + ONE_S > ZERO_S) ? north_w + ONE_S : ZERO_S;
    yhi_w   = (south_w < nr - ONE_S) ? south_w : nr - ONE_S;
  end

  logic                 side_in, side_up;
  logic signed [SW-1:0] start_w, end_w;
  logic signed [SW-1:0] cell_row, cell_col;

  always_comb begin
    unique case (side_r)
      nfc_pkg::SIDE_N: begin
        side_in  = (north_r >= ZERO_S);
        side_up  = 1'b1;
        start_w  = xlo_r;
        end_w    = xhi_r;
        cell_row = north_r;
        cell_col = pos_r;
      end
      nfc_pkg::SIDE_E: begin
        side_in  = (east_r < nc);
        side_up  = 1'b1;
        start_w  = ylo_r;
        end_w    = yhi_r;
        cell_row = pos_r;
        cell_col = east_r;
      end
      nfc_pkg::SIDE_S: begin
        side_in  = (south_r < nr);
        side_up  = 1'b0;
        start_w  = xhi_r - ONE_S;
        end_w    = xlo_r;
        cell_row = south_r;
        cell_col = pos_r;
      end
      default: begin
        side_in  = (west_r >= ZERO_S);
        side_up  = 1'b0;
        start_w  = yhi_r - ONE_S;
        end_w    = ylo_r;
        cell_row = pos_r;
        cell_col = west_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r <= in_action;
      r0_r  <= SW'(in_row);
      c0_r  <= SW'(in_col);
      occ_r <= in_occupied;
      d_r   <= ONE_S;
    end else if (cmd.ring_next) begin
      d_r <= d_r + ONE_S;
    end
    if (cmd.ring_init) begin
      north_r  <= north_w;
      south_r  <= south_w;
      west_r   <= west_w;
      east_r   <= east_w;
      xlo_r    <= xlo_w;
      xhi_r    <= xhi_w;
      ylo_r    <= ylo_w;
      yhi_r    <= yhi_w;
      side_r   <= nfc_pkg::SIDE_N;
      inside_r <= 1'b0;
    end else begin
      if (cmd.side_next) side_r <= side_r + 2'd1;
      if (cmd.side_init) inside_r <= inside_r | side_in;
    end
    if (cmd.side_init) begin
      pos_r <= start_w;
      end_r <= end_w;
    end else if (cmd.step) begin
      pos_r <= side_up ? pos_r + ONE_S : pos_r - ONE_S;
    end
  end

  // occupancy memory: one row of bits per word, rows whose valid bit is clear read as free
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;
  logic [MAX_COLS-1:0] rd_data_r, row_eff, wdata;
  logic                rd_vld_r;
  logic signed [SW-1:0] acc_row, acc_col;
  logic [RA-1:0]       addr;
  logic [CA-1:0]       cidx;
  logic                wen;

  always_comb begin
    acc_row = (act_r == nfc_pkg::ACT_WR) ? r0_r : cell_row;
    acc_col = (act_r == nfc_pkg::ACT_WR) ? c0_r : cell_col;
    addr    = acc_row[RA-1:0];
    cidx    = acc_col[CA-1:0];
    row_eff = rd_vld_r ? rd_data_r : '0;
    wdata   = row_eff;
    wdata[cidx] = cmd.wr_item ? occ_r : 1'b1;
    wen     = cmd.wr_item | cmd.claim;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[addr];
    rd_vld_r  <= row_vld_r[addr];
    if (wen) mem[addr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_vld_r <= '0;
    else if (wen) row_vld_r[addr] <= 1'b1;
  end

  // result
  logic                        hit_r;
  logic [nfc_pkg::COORD_W-1:0] fr_r, fc_r;
  logic                        out_found_r;
  logic [nfc_pkg::COORD_W-1:0] out_row_r, out_col_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) hit_r <= 1'b0;
    else if (cmd.hit)  hit_r <= 1'b1;
    if (cmd.hit) begin
      fr_r <= cell_row[nfc_pkg::COORD_W-1:0];
      fc_r <= cell_col[nfc_pkg::COORD_W-1:0];
    end
    if (cmd.out_load) begin
      out_found_r <= hit_r;
      out_row_r   <= hit_r ? fr_r : '0;
      out_col_r   <= hit_r ? fc_r : '0;
    end
  end

  assign out_found     = out_found_r;
  assign out_found_row = out_row_r;
  assign out_found_col = out_col_r;

  assign sts.act       = act_r;
  assign sts.wr_ok     = (r0_r < MAXR_S) && (c0_r < MAXC_S);
  assign sts.org_ok    = (r0_r < nr) && (c0_r < nc);
  assign sts.side_live = side_in && (side_up ? (start_w <= end_w) : (start_w >= end_w));
  assign sts.side_last = (side_r == nfc_pkg::SIDE_W);
  assign sts.cell_last = (pos_r == end_r);
  assign sts.cell_free = ~row_eff[cidx];
  assign sts.ring_in   = inside_r;

endmodule

// ===== hw/rtl/nfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfc_ctrl: search controller
// Sequences one word at a time through decode, cell write or ring search,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module nfc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nfc_pkg::nfc_sts_t sts,
  output nfc_pkg::nfc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_WRD  = 4'd2;
  localparam logic [3:0] S_WWR  = 4'd3;
  localparam logic [3:0] S_RING = 4'd4;
  localparam logic [3:0] S_SIDE = 4'd5;
  localparam logic [3:0] S_CELL = 4'd6;
  localparam logic [3:0] S_TEST = 4'd7;
  localparam logic [3:0] S_REND = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        priority if (sts.act == nfc_pkg::ACT_WR) begin
          state_nxt = sts.wr_ok ? S_WRD : S_FIN;
        end else if (sts.act == nfc_pkg::ACT_SRCH || sts.act == nfc_pkg::ACT_CLAIM) begin
          state_nxt = sts.org_ok ? S_RING : S_FIN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_WRD: state_nxt = S_WWR;
      S_WWR: begin
        cmd.wr_item = 1'b1;
        state_nxt   = S_FIN;
      end
      S_RING: begin
        cmd.ring_init = 1'b1;
        state_nxt     = S_SIDE;
      end
      S_SIDE: begin
        cmd.side_init = 1'b1;
        priority if (sts.side_live) begin
          state_nxt = S_CELL;
        end else if (sts.side_last) begin
          state_nxt = S_REND;
        end else begin
          cmd.side_next = 1'b1;
        end
      end
      S_CELL: state_nxt = S_TEST;
      S_TEST: begin
        priority if (sts.cell_free) begin
          cmd.hit   = 1'b1;
          cmd.claim = (sts.act == nfc_pkg::ACT_CLAIM);
          state_nxt = S_FIN;
        end else if (!sts.cell_last) begin
          cmd.step  = 1'b1;
          state_nxt = S_CELL;
        end else if (sts.side_last) begin
          state_nxt = S_REND;
        end else begin
          cmd.side_next = 1'b1;
          state_nxt     = S_SIDE;
        end
      end
      S_REND: begin
        if (sts.ring_in) begin
          cmd.ring_next = 1'b1;
          state_nxt     = S_RING;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/nearest_free_cell_ring_search_core.sv =====
// ----------------------------------------------------------------------------
// nearest_free_cell_ring_search_core: nearest free cell search over a grid
// Holds one occupied bit per cell and answers each input word with exactly
// one result word: a cell write, or a square-ring search for a free cell.
// ----------------------------------------------------------------------------
// Usage: each accepted word produces one result word. A write (action 0)
// goes through decode, a row read, the row write and the output handoff. A
// search (action 1, or action 2 that also marks the found cell occupied)
// goes, for each ring visited, through ring setup, a side setup per side
// reached, a read and a test per cell tested, and a ring end unless the
// ring holds the free cell; the occupancy row memory has a single read port
// with registered read data, so each cell is read before it is tested. A
// search from outside the grid, or the unused action, skips to the handoff.
// The next word is taken as soon as the result is moved to the output
// register, even while that result still waits for out_ready. Reset leaves
// every cell free at once through per-row valid bits; no clearing pass runs.
// Write grid_cols and grid_rows only while no word is in progress.
module nearest_free_cell_ring_search_core #(
  parameter int MAX_ROWS = nfc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = nfc_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [nfc_pkg::GRID_W-1:0]    cfg_wdata,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nfc_pkg::ACT_W-1:0]     in_action,
  input  logic [nfc_pkg::COORD_W-1:0]   in_row,
  input  logic [nfc_pkg::COORD_W-1:0]   in_col,
  input  logic                          in_occupied,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [nfc_pkg::COORD_W-1:0]   out_found_row,
  output logic [nfc_pkg::COORD_W-1:0]   out_found_col
);

  nfc_pkg::nfc_cmd_t cmd;
  nfc_pkg::nfc_sts_t sts;

  // sequence decode, ring and side walk, and output handoff
  nfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold grid sizes, occupancy rows, ring bounds and the result word
  nfc_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_action     (in_action),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_occupied   (in_occupied),
    .cmd           (cmd),
    .sts           (sts),
    .out_found     (out_found),
    .out_found_row (out_found_row),
    .out_found_col (out_found_col)
  );

endmodule
